FILE: design/dpt_pkg.sv
// Package for the primality tester: widths, base table and state codes.
`default_nettype none
package dpt_pkg;
   localparam int ValueWidth = 63;
   localparam int BaseCount  = 12;
   localparam int BaseIdxW   = 4;
   localparam int BitIdxW    = 6;
   localparam logic [ValueWidth-1:0] SmallLimit = ValueWidth'(40);

   typedef logic [ValueWidth-1:0] value_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SMALL,
      ST_SETUP,
      ST_BASE_INIT,
      ST_EXP_BIT,
      ST_EXP_SQWAIT,
      ST_EXP_MULWAIT,
      ST_EXP_CHECK,
      ST_SQ_WAIT,
      ST_NEXT_BASE,
      ST_DONE
   } state_type;

   // Command to the shared modular multiplier.
   typedef struct packed {
      logic      go;
      value_type x;
      value_type y;
   } mul_cmd_type;

   function automatic value_type base_value(input logic [BaseIdxW-1:0] idx);
      value_type v;
      case (idx)
         4'd0:    v = ValueWidth'(2);
         4'd1:    v = ValueWidth'(3);
         4'd2:    v = ValueWidth'(5);
         4'd3:    v = ValueWidth'(7);
         4'd4:    v = ValueWidth'(11);
         4'd5:    v = ValueWidth'(13);
         4'd6:    v = ValueWidth'(17);
         4'd7:    v = ValueWidth'(19);
         4'd8:    v = ValueWidth'(23);
         4'd9:    v = ValueWidth'(29);
         4'd10:   v = ValueWidth'(31);
         4'd11:   v = ValueWidth'(37);
         default: v = ValueWidth'(2);
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

FILE: design/dpt_mulmod.sv
// Bit-serial modular multiplier: one double-and-add step per cycle.
`default_nettype none
module dpt_mulmod
   import dpt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_cmd_type cmd,
   input  wire value_type   modulus,
   output logic             done,
   output value_type        product
);
   logic              busy_ff, busy_in;
   logic [BitIdxW-1:0] bit_ff, bit_in;
   value_type         acc_ff, acc_in, x_ff, x_in, y_ff, y_in;
   logic              done_ff, done_in;
   logic [ValueWidth:0] dbl, dbl_r, sum;
   value_type           dbl_v;

   // One step: acc = 2*acc mod m, then add x mod m when the y bit is set.
   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      dbl_v = dbl_r[ValueWidth-1:0];
      sum   = {1'b0, dbl_v} + {1'b0, x_ff};
      if (sum >= {1'b0, modulus}) sum = sum - {1'b0, modulus};
      busy_in = busy_ff;
      bit_in  = bit_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      done_in = 1'b0;
      if (cmd.go) begin
         busy_in = 1'b1;
         bit_in  = BitIdxW'(ValueWidth - 1);
         acc_in  = '0;
         x_in    = cmd.x;
         y_in    = cmd.y;
      end else if (busy_ff) begin
         acc_in = y_ff[bit_ff] ? sum[ValueWidth-1:0] : dbl_v;
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

FILE: design/deterministic_primality_test.sv
// Top level: strong Miller-Rabin test over bases 2 to 37 with one shared multiplier.
// A large prime runs the full test over all 12 bases; values of 40 or less are
// answered from the base table without it. The multiplier, one bit per cycle, sets
// the pace of the test. One item at a time: busy is high meanwhile.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Synchronous active-high reset returns the sequencer to idle; no clearing pass.
`default_nettype none
module deterministic_primality_test
   import dpt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   output logic           busy,
   input  wire value_type req_candidate,
   output logic           rsp_valid,
   output logic           rsp_is_prime
);
   state_type            state_ff, state_in;
   value_type            n_ff, n_in, q_ff, q_in, y_ff, y_in, p_ff, p_in;
   logic [BaseIdxW-1:0]  base_ff, base_in;
   logic [BitIdxW-1:0]   ebit_ff, ebit_in, s_ff, s_in, cnt_ff, cnt_in;
   logic                 prime_ff, prime_in, valid_ff, valid_in;
   mul_cmd_type          cmd;
   logic                 mul_done;
   value_type            product, nm1, base_v;
   logic                 is_small_prime;

   dpt_mulmod u_mul (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .modulus(n_ff),
      .done   (mul_done),
      .product(product)
   );

   assign nm1    = n_ff - 1'b1;
   assign base_v = base_value(base_ff);

   // Small candidates are prime exactly when they appear in the base list.
   always_comb begin
      is_small_prime = 1'b0;
      for (int i = 0; i < BaseCount; i++) begin
         if (n_ff == base_value(BaseIdxW'(i))) is_small_prime = 1'b1;
      end
   end

   // Sequencer: small-value check, split of n-1, then bases, exponent bits and squarings.
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      q_in     = q_ff;
      y_in     = y_ff;
      p_in     = p_ff;
      base_in  = base_ff;
      ebit_in  = ebit_ff;
      s_in     = s_ff;
      cnt_in   = cnt_ff;
      prime_in = prime_ff;
      valid_in = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in     = req_candidate;
               state_in = ST_SMALL;
            end
         end
         ST_SMALL: begin
            if (n_ff <= SmallLimit) begin
               prime_in = is_small_prime;
               state_in = ST_DONE;
            end else begin
               // Split n-1 into q * 2^s, one shift per cycle.
               q_in     = nm1;
               s_in     = '0;
               base_in  = '0;
               prime_in = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (q_ff[0] == 1'b0) begin
               q_in = q_ff >> 1;
               s_in = s_ff + 1'b1;
            end else begin
               state_in = ST_BASE_INIT;
            end
         end
         ST_BASE_INIT: begin
            // A base that divides n needs no separate check: every power of it
            // mod n is then a multiple of the base, so it never equals 1 or n-1
            // and the base is always reported as a witness.
            y_in     = ValueWidth'(1);
            p_in     = base_v;
            ebit_in  = '0;
            state_in = ST_EXP_BIT;
         end
         ST_EXP_BIT: begin
            // Right-to-left exponentiation over the bits of q.
            if ((q_ff >> ebit_ff) == '0) begin
               state_in = ST_EXP_CHECK;
            end else if (q_ff[ebit_ff]) begin
               cmd      = '{go: 1'b1, x: y_ff, y: p_ff};
               state_in = ST_EXP_MULWAIT;
            end else begin
               cmd      = '{go: 1'b1, x: p_ff, y: p_ff};
               state_in = ST_EXP_SQWAIT;
            end
         end
         ST_EXP_MULWAIT: begin
            if (mul_done) begin
               y_in     = product;
               cmd      = '{go: 1'b1, x: p_ff, y: p_ff};
               state_in = ST_EXP_SQWAIT;
            end
         end
         ST_EXP_SQWAIT: begin
            if (mul_done) begin
               p_in     = product;
               if (ebit_ff == BitIdxW'(ValueWidth - 1)) state_in = ST_EXP_CHECK;
               else begin
                  ebit_in  = ebit_ff + 1'b1;
                  state_in = ST_EXP_BIT;
               end
            end
         end
         ST_EXP_CHECK: begin
            cnt_in = BitIdxW'(1);
            if (y_ff == ValueWidth'(1) || y_ff == nm1) state_in = ST_NEXT_BASE;
            else if (s_ff <= BitIdxW'(1)) begin
               prime_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               cmd      = '{go: 1'b1, x: y_ff, y: y_ff};
               state_in = ST_SQ_WAIT;
            end
         end
         ST_SQ_WAIT: begin
            if (mul_done) begin
               y_in = product;
               if (product == nm1) state_in = ST_NEXT_BASE;
               else if (cnt_ff + 1'b1 >= s_ff) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  cmd    = '{go: 1'b1, x: product, y: product};
               end
            end
         end
         ST_NEXT_BASE: begin
            if (base_ff == BaseIdxW'(BaseCount - 1)) state_in = ST_DONE;
            else begin
               base_in  = base_ff + 1'b1;
               state_in = ST_BASE_INIT;
            end
         end
         ST_DONE: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      n_ff     <= n_in;
      q_ff     <= q_in;
      y_ff     <= y_in;
      p_ff     <= p_in;
      base_ff  <= base_in;
      ebit_ff  <= ebit_in;
      s_ff     <= s_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = valid_ff;
   assign rsp_is_prime = prime_ff;

   // A result transfer follows the final state of a test.
   a_valid_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DONE)) else $error("strobe without done");
   // The multiplier is started only while the sequencer is running.
   a_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.go |-> busy) else $error("multiplier started when idle");
   // A new test begins only from idle.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == ST_SMALL) else $error("accept not taken");
endmodule
`default_nettype wire
